// ===== sv/ewef_pkg.sv =====
`timescale 1ns / 1ps

package ewef_pkg;

  // Store geometry
  localparam int STORE_DEPTH = 32;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  // Field widths
  localparam int TIME_W  = 32;
  localparam int WORD_W  = 32;
  localparam int COORD_W = 14;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd10000;

  // Operation codes
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // One held event
  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               pol;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Classified command from the front end
  typedef struct packed {
    logic   flush;
    entry_t ev;
  } cmd_t;

  // Wrapping pointer advance
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    next_slot = (i == IDX_W'(STORE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

endpackage

// ===== sv/event_window_expiry_fifo_core.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    operation, event_time, event_word
// out      output     out_valid/out_ready  pos_x, pos_y, polarity_on, stamp,
//                                          leaving, forced_out, last_of_run
// cfg      input      cfg_we (no wait)     cfg_wdata -> window_length
//
// The first result of an item passes the select, store read and evaluate
// steps; each further result passes the store read and evaluate steps again.
// An empty flush gives no result. A stalled result holds the evaluate step;
// the two-entry command queue keeps taking inputs meanwhile until it is full.
// Synchronous reset empties the store and the queue; the window returns to 10000.

module event_window_expiry_fifo_core import ewef_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [TIME_W-1:0]  cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [TIME_W-1:0]  event_time,
  input  logic [WORD_W-1:0]  event_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] pos_x,
  output logic [COORD_W-1:0] pos_y,
  output logic               polarity_on,
  output logic [TIME_W-1:0]  stamp,
  output logic               leaving,
  output logic               forced_out,
  output logic               last_of_run
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Accept and classify
  ewef_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .event_time(event_time),
    .event_word(event_word),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Window store and result sequencing
  ewef_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .polarity_on(polarity_on),
    .stamp      (stamp),
    .leaving    (leaving),
    .forced_out (forced_out),
    .last_of_run(last_of_run)
  );

endmodule

// ===== sv/ewef_ram.sv =====
`timescale 1ns / 1ps

module ewef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/ewef_front.sv =====
`timescale 1ns / 1ps

module ewef_front import ewef_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [TIME_W-1:0] event_time,
  input  logic [WORD_W-1:0] event_word,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       decoded;
  logic       push;

  // Unpack the event word
  always_comb begin
    decoded.flush    = (operation == OP_FLUSH);
    decoded.ev.stamp = event_time;
    decoded.ev.x     = event_word[COORD_W-1:0];
    decoded.ev.y     = event_word[2*COORD_W-1:COORD_W];
    decoded.ev.pol   = |event_word[WORD_W-1:2*COORD_W];
  end

  assign in_ready  = (fill != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slots[rd_ptr];

  // Two-entry command queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(cmd_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

endmodule

// ===== sv/ewef_back.sv =====
`timescale 1ns / 1ps

module ewef_back import ewef_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [TIME_W-1:0]  cfg_wdata,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] pos_x,
  output logic [COORD_W-1:0] pos_y,
  output logic               polarity_on,
  output logic [TIME_W-1:0]  stamp,
  output logic               leaving,
  output logic               forced_out,
  output logic               last_of_run
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EVAL
  } state_t;

  state_t            state;
  cmd_t              cur;
  logic              forced_done;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [CNT_W-1:0]  count;
  logic [TIME_W-1:0] window;
  entry_t            oldest;

  logic slot_free;
  logic expire_hit;
  logic store_full;
  logic force_go;
  logic arrive_go;
  logic emit_go;

  // Event store; read port always follows the head
  ewef_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (arrive_go),
    .wr_addr(tail),
    .wr_data(cur.ev),
    .rd_addr(head),
    .rd_data(oldest)
  );

  // Decisions for the evaluate step
  assign slot_free  = !out_valid || out_ready;
  assign expire_hit = (count != '0) && !forced_done &&
                      ((oldest.stamp + window) <= cur.ev.stamp);
  assign store_full = (count == CNT_W'(STORE_DEPTH));
  assign force_go   = !expire_hit && store_full && !forced_done;
  assign arrive_go  = (state == S_EVAL) && !cur.flush && slot_free &&
                      !expire_hit && !force_go;
  assign emit_go    = (state == S_EVAL) && slot_free && (!cur.flush || (count != '0));
  assign cmd_pop    = (state == S_IDLE) && cmd_valid;

  // Sequencer, pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      forced_done <= 1'b0;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      window      <= WINDOW_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        window <= cfg_wdata;
      end
      // a new result loads, a taken one clears, a stalled one holds
      out_valid <= emit_go || (out_valid && !out_ready);

      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur         <= cmd;
            forced_done <= 1'b0;
            state       <= S_LOAD;
          end
        end

        // wait state: the read register takes the head entry before the evaluate step
        S_LOAD: begin
          state <= S_EVAL;
        end

        S_EVAL: begin
          if (cur.flush) begin
            if (count == '0) begin
              state <= S_IDLE;
            end else if (slot_free) begin
              pos_x       <= oldest.x;
              pos_y       <= oldest.y;
              polarity_on <= oldest.pol;
              stamp       <= oldest.stamp;
              leaving     <= 1'b1;
              forced_out  <= 1'b0;
              last_of_run <= (count == CNT_W'(1));
              head        <= next_slot(head);
              count       <= count - CNT_W'(1);
              state       <= (count == CNT_W'(1)) ? S_IDLE : S_LOAD;
            end
          end else if (slot_free) begin
            if (expire_hit || force_go) begin
              pos_x       <= oldest.x;
              pos_y       <= oldest.y;
              polarity_on <= oldest.pol;
              stamp       <= oldest.stamp;
              leaving     <= 1'b1;
              forced_out  <= force_go;
              last_of_run <= 1'b0;
              head        <= next_slot(head);
              count       <= count - CNT_W'(1);
              if (force_go) begin
                forced_done <= 1'b1;
              end
              state <= S_LOAD;
            end else begin
              // arrival: report it and queue it at the tail
              pos_x       <= cur.ev.x;
              pos_y       <= cur.ev.y;
              polarity_on <= cur.ev.pol;
              stamp       <= cur.ev.stamp;
              leaving     <= 1'b0;
              forced_out  <= 1'b0;
              last_of_run <= 1'b1;
              tail        <= next_slot(tail);
              count       <= count + CNT_W'(1);
              state       <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/ewef_checker.sv =====
`timescale 1ns / 1ps

module ewef_checker import ewef_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               operation,
  input logic [TIME_W-1:0]  event_time,
  input logic [WORD_W-1:0]  event_word,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COORD_W-1:0] pos_x,
  input logic [COORD_W-1:0] pos_y,
  input logic               polarity_on,
  input logic [TIME_W-1:0]  stamp,
  input logic               leaving,
  input logic               forced_out,
  input logic               last_of_run
);

  // A waiting input transfer holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(operation) &&
      $stable(event_time) && $stable(event_word))
    else $error("waiting input changed");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(stamp) && $stable(pos_x) &&
      $stable(pos_y) && $stable(polarity_on) && $stable(leaving) &&
      $stable(forced_out) && $stable(last_of_run))
    else $error("stalled result changed");

  // Reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // An arrival always closes its run
  a_arrival_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !leaving |-> last_of_run)
    else $error("arrival not last of run");

  // A forced eviction is an expiry followed by the arrival
  a_forced_expiry: assert property (@(posedge clk) disable iff (rst)
    out_valid && forced_out |-> leaving && !last_of_run)
    else $error("bad forced eviction flags");

endmodule

bind event_window_expiry_fifo_core ewef_checker u_ewef_checker (.*);
